### rtl/ptz_pkg.sv
package ptz_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 2 * BYTE_W;
  localparam int KIND_W  = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_PAN     = 8'h59;
  localparam logic [BYTE_W-1:0] CMD_TILT    = 8'h5B;
  localparam logic [BYTE_W-1:0] CMD_STAT_HI = 8'h8E;
  localparam logic [BYTE_W-1:0] CMD_STAT_LO = 8'hE9;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAN,
    KIND_TILT,
    KIND_STATUS
  } kind_t;

  // decoded frame waiting for the output stage: bytes 4 and 5, big-endian
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
  } ptz_rec_t;

endpackage

### rtl/ptz_byte_if.sv
interface ptz_byte_if;
  import ptz_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/ptz_report_if.sv
interface ptz_report_if;
  import ptz_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] report_kind;
  logic [WORD_W-1:0] angle_value;
  logic [BYTE_W-1:0] optical_state;
  logic [BYTE_W-1:0] infrared_state;

  modport source (output valid, output report_kind, output angle_value,
                  output optical_state, output infrared_state, input ready);
  modport sink   (input valid, input report_kind, input angle_value,
                  input optical_state, input infrared_state, output ready);
endinterface

### rtl/ptz_front.sv
module ptz_front (
  input  logic              clk,
  input  logic              rst_n,
  ptz_byte_if.sink          in_ch,
  input  logic              q_full,
  output logic              push,
  output ptz_pkg::ptz_rec_t push_rec
);
  import ptz_pkg::*;

  // position of the next byte in the frame; POS_HUNT waits for sync
  typedef enum logic [2:0] {
    POS_HUNT, POS_B1, POS_B2, POS_B3, POS_B4, POS_B5, POS_B6, POS_B7
  } pos_t;

  pos_t              pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] b2_r, b2_nxt;
  logic [BYTE_W-1:0] b3_r, b3_nxt;
  logic [BYTE_W-1:0] b4_r, b4_nxt;
  logic [BYTE_W-1:0] b5_r, b5_nxt;
  logic              fire;
  logic [BYTE_W-1:0] rx;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign rx          = in_ch.rx_byte;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    b2_nxt   = b2_r;
    b3_nxt   = b3_r;
    b4_nxt   = b4_r;
    b5_nxt   = b5_r;
    push     = 1'b0;
    push_rec = '{kind: KIND_PAN, word: {b4_r, b5_r}};
    if (fire) begin
      if (rx == SYNC_BYTE) begin
        // sync always restarts the frame
        pos_nxt = POS_B1;
        sum_nxt = '0;
      end else begin
        case (pos_r)
          POS_HUNT: begin
            pos_nxt = POS_HUNT;
          end
          POS_B1: begin
            sum_nxt = sum_r + rx;
            pos_nxt = POS_B2;
          end
          POS_B2: begin
            sum_nxt = sum_r + rx;
            b2_nxt  = rx;
            pos_nxt = POS_B3;
          end
          POS_B3: begin
            sum_nxt = sum_r + rx;
            b3_nxt  = rx;
            pos_nxt = POS_B4;
          end
          POS_B4: begin
            sum_nxt = sum_r + rx;
            b4_nxt  = rx;
            pos_nxt = POS_B5;
          end
          POS_B5: begin
            sum_nxt = sum_r + rx;
            b5_nxt  = rx;
            pos_nxt = POS_B6;
          end
          POS_B6: begin
            if (sum_r == rx) begin
              if (b3_r == CMD_PAN) begin
                push          = 1'b1;
                push_rec.kind = KIND_PAN;
              end else if (b3_r == CMD_TILT) begin
                push          = 1'b1;
                push_rec.kind = KIND_TILT;
              end else if (b2_r == CMD_STAT_HI && b3_r == CMD_STAT_LO) begin
                push          = 1'b1;
                push_rec.kind = KIND_STATUS;
              end
              pos_nxt = POS_HUNT;
              sum_nxt = '0;
            end else begin
              // bad checksum: swallow one more byte before hunting
              pos_nxt = POS_B7;
            end
          end
          POS_B7: begin
            pos_nxt = POS_HUNT;
            sum_nxt = '0;
          end
          default: begin
            pos_nxt = POS_HUNT;
            sum_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
    b2_r <= b2_nxt;
    b3_r <= b3_nxt;
    b4_r <= b4_nxt;
    b5_r <= b5_nxt;
  end

endmodule

### rtl/ptz_queue.sv
module ptz_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ptz_pkg::ptz_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ptz_pkg::ptz_rec_t head_rec
);
  import ptz_pkg::*;

  ptz_rec_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### rtl/ptz_back.sv
module ptz_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ptz_pkg::ptz_rec_t q_rec,
  output logic              q_pop,
  ptz_report_if.source      out_ch
);
  import ptz_pkg::*;

  logic              valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [WORD_W-1:0] angle_r;
  logic [BYTE_W-1:0] optical_r;
  logic [BYTE_W-1:0] infrared_r;
  logic              load;
  logic              is_status;

  // refill whenever the output register is empty or being taken
  assign load      = q_valid && (!valid_r || out_ch.ready);
  assign q_pop     = load;
  assign is_status = (q_rec.kind == KIND_STATUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      kind_r     <= q_rec.kind;
      angle_r    <= is_status ? '0 : q_rec.word;
      optical_r  <= is_status ? q_rec.word[WORD_W-1:BYTE_W] : '0;
      infrared_r <= is_status ? q_rec.word[BYTE_W-1:0] : '0;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.report_kind    = kind_r;
  assign out_ch.angle_value    = angle_r;
  assign out_ch.optical_state  = optical_r;
  assign out_ch.infrared_state = infrared_r;

endmodule

### rtl/ptz_reply_frame_parser.sv
// Path: a report goes from the framer into the report queue, then into the output register on out_ch.
// Throughput: one byte per cycle when not stalled; the framer holds at most one byte of work.
// in_ch.ready drops only while the 2-entry report queue is full, which needs the
// output register to be stalled as well.
// Reset: synchronous, active low; clears framing position, checksum, queue and output valid.
module ptz_reply_frame_parser (
  input  logic         clk,
  input  logic         rst_n,
  ptz_byte_if.sink     in_ch,
  ptz_report_if.source out_ch
);
  import ptz_pkg::*;

  logic     push;
  ptz_rec_t push_rec;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  ptz_rec_t q_rec;

  ptz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  ptz_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (q_rec)
  );

  ptz_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/ptz_checker.sv
module ptz_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ptz_pkg::KIND_W-1:0] report_kind,
  input logic [ptz_pkg::WORD_W-1:0] angle_value,
  input logic [ptz_pkg::BYTE_W-1:0] optical_state,
  input logic [ptz_pkg::BYTE_W-1:0] infrared_state
);
  import ptz_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(report_kind) &&
      $stable(angle_value) && $stable(optical_state) && $stable(infrared_state))
    else $error("report changed while stalled");

  a_status_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && report_kind == KIND_STATUS |-> angle_value == '0)
    else $error("status report carries an angle");

  a_angle_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && report_kind != KIND_STATUS |-> optical_state == '0 && infrared_state == '0)
    else $error("angle report carries status bytes");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready && out_valid))
    else $error("input stalled without a waiting report");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind ptz_reply_frame_parser ptz_checker u_ptz_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .report_kind    (out_ch.report_kind),
  .angle_value    (out_ch.angle_value),
  .optical_state  (out_ch.optical_state),
  .infrared_state (out_ch.infrared_state)
);
